[src/vector3_normalize_assert.svh]
// ----------------------------------------------------------------------------
// Vector normalise assertion macros
// Shared property shapes for the checker of the normalise block.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define VN_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("vector3_normalize: implication failed");

// Check that a condition implies a consequence in the next cycle.
`define VN_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("vector3_normalize: next-cycle check failed");

`endif

[src/vn_pkg.sv]
// ----------------------------------------------------------------------------
// Vector normalise package
// Widths, stage counts and the side-band type carried past the root unit.
// ----------------------------------------------------------------------------
package vn_pkg;

   localparam int WORD_W      = 32;
   localparam int SUM_W       = 64;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;
   localparam int QUOT_W      = 31;

   typedef struct packed {
      logic [WORD_W-1:0] mag_x;
      logic [WORD_W-1:0] mag_y;
      logic [WORD_W-1:0] mag_z;
      logic              neg_x;
      logic              neg_y;
      logic              neg_z;
   } tag_type;

endpackage

[src/vn_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage over a 64-bit radicand, side-band travels along.
// ----------------------------------------------------------------------------
module vn_isqrt (
   input  logic                      clock,
   input  logic                      en,
   input  logic [vn_pkg::SUM_W-1:0]  sum,
   input  vn_pkg::tag_type           tag_in,
   output logic [vn_pkg::WORD_W-1:0] root,
   output vn_pkg::tag_type           tag_out
);
   import vn_pkg::*;

   localparam int N = SQRT_STAGES;

   logic [WORD_W:0]   rem_ff  [0:N-1];
   logic [WORD_W-1:0] root_ff [0:N-1];
   logic [SUM_W-1:0]  v_ff    [0:N-1];
   tag_type           tag_ff  [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [WORD_W:0]   src_rem;
      logic [WORD_W-1:0] src_root;
      logic [SUM_W-1:0]  src_v;
      tag_type           src_tag;
      logic [WORD_W+2:0] rem2;
      logic [WORD_W+2:0] trial;
      logic [WORD_W+2:0] diff;
      logic              ge;
      logic [WORD_W:0]   rem_in;
      logic [WORD_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_v    = sum;
         assign src_tag  = tag_in;
      end else begin : g_rest
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_v    = v_ff[k-1];
         assign src_tag  = tag_ff[k-1];
      end

      always_comb begin
         rem2    = {src_rem, src_v[SUM_W-1:SUM_W-2]};
         trial   = {1'b0, src_root, 2'b01};
         diff    = rem2 - trial;
         ge      = (rem2 >= trial);
         rem_in  = ge ? diff[WORD_W:0] : rem2[WORD_W:0];
         root_in = {src_root[WORD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            v_ff[k]    <= {src_v[SUM_W-3:0], 2'b00};
            tag_ff[k]  <= src_tag;
         end
      end
   end

   assign root    = root_ff[N-1];
   assign tag_out = tag_ff[N-1];

endmodule

[src/vn_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider lane
// Computes (mag << 30) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [vn_pkg::WORD_W-1:0] mag,
   input  logic                      neg_in,
   input  logic [vn_pkg::WORD_W-1:0] len_in,
   output logic [vn_pkg::QUOT_W-1:0] quot,
   output logic                      neg_out,
   output logic [vn_pkg::WORD_W-1:0] len_out
);
   import vn_pkg::*;

   localparam int N = DIV_STAGES;

   logic [WORD_W-1:0] rem_ff [0:N-1];
   logic [QUOT_W-1:0] q_ff   [0:N-1];
   logic [WORD_W-1:0] len_ff [0:N-1];
   logic              neg_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [WORD_W-1:0] src_rem;
      logic [QUOT_W-1:0] src_q;
      logic [WORD_W-1:0] src_len;
      logic              src_neg;
      logic              nbit;
      logic [WORD_W:0]   rem2;
      logic [WORD_W:0]   diff;
      logic              ge;
      logic [WORD_W-1:0] rem_in;

      if (k == 0) begin : g_first
         // mag >> 1 is below len whenever len is nonzero
         assign src_rem = {1'b0, mag[WORD_W-1:1]};
         assign src_q   = '0;
         assign src_len = len_in;
         assign src_neg = neg_in;
         assign nbit    = mag[0];
      end else begin : g_rest
         assign src_rem = rem_ff[k-1];
         assign src_q   = q_ff[k-1];
         assign src_len = len_ff[k-1];
         assign src_neg = neg_ff[k-1];
         assign nbit    = 1'b0;
      end

      always_comb begin
         rem2   = {src_rem, nbit};
         diff   = rem2 - {1'b0, src_len};
         ge     = (rem2 >= {1'b0, src_len});
         rem_in = ge ? diff[WORD_W-1:0] : rem2[WORD_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= {src_q[QUOT_W-2:0], ge};
            len_ff[k] <= src_len;
            neg_ff[k] <= src_neg;
         end
      end
   end

   assign quot    = q_ff[N-1];
   assign neg_out = neg_ff[N-1];
   assign len_out = len_ff[N-1];

endmodule

[src/vector3_normalize.sv]
// ----------------------------------------------------------------------------
// Three-dimensional vector normalise
// Length and unit vector of a signed Q16.16 vector, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall) takes one vector per beat,
//   three signed Q16.16 components. The response channel (rsp_valid /
//   rsp_stall) returns one beat per vector: the truncated Euclidean length in
//   unsigned Q16.16, the unit vector in signed Q1.30 rounded toward zero,
//   and is_zero for the all-zero vector (length and unit fields then zero).
//   The pipe holds 67 register stages; rsp_valid is the valid bit of the
//   last stage, set when the request beat reaches the output stage.
//   The stages are one input stage, one squaring stage, one sum stage,
//   32 root stages (one root bit each), 31 divider stages (one quotient bit
//   each, three lanes) and one output stage. Throughput is one vector per
//   cycle while the response is not stalled.
//   All stages share one advance enable: when the response is held and
//   stalled, the whole pipe freezes and req_stall rises; nothing is lost or
//   repeated. While the response side takes beats, a new request is taken
//   every cycle. Reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module vector3_normalize (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [31:0]        req_vec_x,
   input  logic signed [31:0]        req_vec_y,
   input  logic signed [31:0]        req_vec_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_length,
   output logic signed [31:0]        rsp_unit_x,
   output logic signed [31:0]        rsp_unit_y,
   output logic signed [31:0]        rsp_unit_z,
   output logic                      rsp_is_zero
);
   import vn_pkg::*;

   localparam int LAT = 3 + SQRT_STAGES + DIV_STAGES + 1;

   logic           en;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // input stage: magnitudes and signs
   tag_type           in_tag_ff;
   // squaring stage
   logic [SUM_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   tag_type           sq_tag_ff;
   // sum stage
   logic [SUM_W-1:0]  sum_ff;
   tag_type           sum_tag_ff;

   logic [WORD_W-1:0] root;
   tag_type           root_tag;

   logic [QUOT_W-1:0] qx, qy, qz;
   logic              nx, ny, nz, ny_unused, nz_unused;
   logic [WORD_W-1:0] len_d, len_y_unused, len_z_unused;

   logic [WORD_W-1:0] len_ff;
   logic [WORD_W-1:0] ux_ff, uy_ff, uz_ff;
   logic              zero_ff;

   // freeze everything while a finished beat is held by the receiver
   assign en        = ~(vld_ff[LAT-1] & rsp_stall);
   assign req_stall = ~en;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] w);
      mag_of = w[WORD_W-1] ? (~w + 1'b1) : w;
   endfunction

   function automatic logic [WORD_W-1:0] signed_unit(input logic [QUOT_W-1:0] q,
                                                     input logic neg);
      logic [WORD_W-1:0] u;
      u = {1'b0, q};
      signed_unit = neg ? (~u + 1'b1) : u;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         in_tag_ff.mag_x <= mag_of(req_vec_x);
         in_tag_ff.mag_y <= mag_of(req_vec_y);
         in_tag_ff.mag_z <= mag_of(req_vec_z);
         in_tag_ff.neg_x <= req_vec_x[WORD_W-1];
         in_tag_ff.neg_y <= req_vec_y[WORD_W-1];
         in_tag_ff.neg_z <= req_vec_z[WORD_W-1];

         sq_x_ff   <= SUM_W'(in_tag_ff.mag_x) * SUM_W'(in_tag_ff.mag_x);
         sq_y_ff   <= SUM_W'(in_tag_ff.mag_y) * SUM_W'(in_tag_ff.mag_y);
         sq_z_ff   <= SUM_W'(in_tag_ff.mag_z) * SUM_W'(in_tag_ff.mag_z);
         sq_tag_ff <= in_tag_ff;

         // sum of three squares stays below 2^64
         sum_ff     <= sq_x_ff + sq_y_ff + sq_z_ff;
         sum_tag_ff <= sq_tag_ff;
      end
   end

   vn_isqrt u_isqrt (
      .clock   (clock),
      .en      (en),
      .sum     (sum_ff),
      .tag_in  (sum_tag_ff),
      .root    (root),
      .tag_out (root_tag)
   );

   vn_div u_div_x (
      .clock (clock), .en (en), .mag (root_tag.mag_x), .neg_in (root_tag.neg_x),
      .len_in (root), .quot (qx), .neg_out (nx), .len_out (len_d)
   );
   vn_div u_div_y (
      .clock (clock), .en (en), .mag (root_tag.mag_y), .neg_in (root_tag.neg_y),
      .len_in (root), .quot (qy), .neg_out (ny), .len_out (len_y_unused)
   );
   vn_div u_div_z (
      .clock (clock), .en (en), .mag (root_tag.mag_z), .neg_in (root_tag.neg_z),
      .len_in (root), .quot (qz), .neg_out (nz), .len_out (len_z_unused)
   );

   assign ny_unused = ny;
   assign nz_unused = nz;

   // output stage: apply signs, force zeros for the zero vector
   always_ff @(posedge clock) begin
      if (en) begin
         len_ff  <= len_d;
         zero_ff <= (len_d == '0);
         if (len_d == '0) begin
            ux_ff <= '0;
            uy_ff <= '0;
            uz_ff <= '0;
         end else begin
            ux_ff <= signed_unit(qx, nx);
            uy_ff <= signed_unit(qy, ny_unused);
            uz_ff <= signed_unit(qz, nz_unused);
         end
      end
   end

   assign rsp_valid   = vld_ff[LAT-1];
   assign rsp_length  = len_ff;
   assign rsp_unit_x  = ux_ff;
   assign rsp_unit_y  = uy_ff;
   assign rsp_unit_z  = uz_ff;
   assign rsp_is_zero = zero_ff;

endmodule

[src/vn_checker.sv]
// ----------------------------------------------------------------------------
// Vector normalise port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "vector3_normalize_assert.svh"

module vn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_length,
   input logic [31:0] rsp_unit_x,
   input logic [31:0] rsp_unit_y,
   input logic [31:0] rsp_unit_z,
   input logic        rsp_is_zero
);

   logic fields_zero;

   assign fields_zero = (rsp_length == 32'd0) && (rsp_unit_x == 32'd0) &&
                        (rsp_unit_y == 32'd0) && (rsp_unit_z == 32'd0);

   `VN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `VN_ASSERT_IMPL(a_stall_link, clock, reset, 1'b1, req_stall == (rsp_valid && rsp_stall))
   `VN_ASSERT_IMPL(a_zero_fields, clock, reset, rsp_valid && rsp_is_zero, fields_zero)
   `VN_ASSERT_IMPL(a_nonzero_len, clock, reset, rsp_valid && !rsp_is_zero, rsp_length != 32'd0)

endmodule

bind vector3_normalize vn_checker u_vn_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_length  (rsp_length),
   .rsp_unit_x  (rsp_unit_x),
   .rsp_unit_y  (rsp_unit_y),
   .rsp_unit_z  (rsp_unit_z),
   .rsp_is_zero (rsp_is_zero)
);
